[rtl/core/window_level_pixel_colormap_macros.svh]
// ----------------------------------------------------------------------------
// window level pixel colormap assertion macros
// shared property forms for the block's concurrent checks
// ----------------------------------------------------------------------------
`ifndef WINDOW_LEVEL_PIXEL_COLORMAP_MACROS_SVH
`define WINDOW_LEVEL_PIXEL_COLORMAP_MACROS_SVH

// same-cycle implication
`define WLPC_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WLPC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/wlpc_pkg.sv]
// ----------------------------------------------------------------------------
// wlpc_pkg
// constants, codes, stage map and byte helpers of the colormap pipeline
// ----------------------------------------------------------------------------
package wlpc_pkg;

   localparam int NUM_CH    = 4;
   localparam int DIV_STEPS = 17;
   localparam int T_W       = 17;

   localparam logic [T_W-1:0] ONE_Q16  = 17'd65536;
   localparam logic [T_W-1:0] HALF_Q16 = 17'd32768;
   localparam logic [7:0]     BYTE_MAX = 8'd255;

   // register map
   localparam int         REG_IDX_W         = 3;
   localparam logic [2:0] REG_WINDOW_LOW    = 3'd0;
   localparam logic [2:0] REG_WINDOW_HIGH   = 3'd1;
   localparam logic [2:0] REG_INVERT        = 3'd2;
   localparam logic [2:0] REG_COLOR_MODE    = 3'd3;
   localparam logic [2:0] REG_RAMP_BEGIN    = 3'd4;
   localparam logic [2:0] REG_RAMP_END      = 3'd5;
   localparam logic [2:0] REG_MISSING_COLOR = 3'd6;
   localparam logic [2:0] REG_STOP_COUNT    = 3'd7;

   localparam logic [1:0] MODE_GRAY = 2'd0;
   localparam logic [1:0] MODE_RGB  = 2'd1;
   localparam logic [1:0] MODE_RGBA = 2'd2;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_STOP  = 1'b1;

   // pipeline stage map
   localparam int ST_IN      = 0;
   localparam int ST_DIFF    = 1;
   localparam int ST_DIV0    = 2;
   localparam int ST_DIVN    = ST_DIV0 + DIV_STEPS;
   localparam int ST_LEVEL   = ST_DIVN + 1;
   localparam int ST_MUL     = ST_LEVEL + 1;
   localparam int ST_BAND    = ST_MUL + 1;
   localparam int ST_SCALE   = ST_BAND + 1;
   localparam int ST_RDATA   = ST_SCALE + 1;
   localparam int ST_OUT     = ST_RDATA + 1;
   localparam int NUM_STAGES = ST_OUT + 1;

   typedef struct packed {
      logic        kind;
      logic [3:0]  valid_mask;
      logic [3:0]  stop_index;
      logic [23:0] stop_rgb;
   } side_type;

   // (x*255 + half) >> 16
   function automatic logic [7:0] to_byte(input logic [T_W-1:0] x);
      logic [24:0] p;
      p = 25'(x) * 25'(BYTE_MAX) + 25'(HALF_Q16);
      return p[23:16];
   endfunction

   // (a*(1-f) + b*f + half) >> 16
   function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                        input logic [15:0] f);
      logic [24:0] p;
      logic [T_W-1:0] fc;
      fc = ONE_Q16 - {1'b0, f};
      p  = 25'(a) * 25'(fc) + 25'(b) * 25'(f) + 25'(HALF_Q16);
      return p[23:16];
   endfunction

endpackage

[rtl/core/wlpc_req_if.sv]
// ----------------------------------------------------------------------------
// wlpc_req_if
// input channel: pixel samples or one colour stop write per word
// ----------------------------------------------------------------------------
interface wlpc_req_if #(
   parameter int SAMPLE_BITS = 32
);
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic signed [SAMPLE_BITS-1:0] sample_0;
   logic signed [SAMPLE_BITS-1:0] sample_1;
   logic signed [SAMPLE_BITS-1:0] sample_2;
   logic signed [SAMPLE_BITS-1:0] sample_3;
   logic [3:0]                    valid_mask;
   logic [3:0]                    stop_index;
   logic [23:0]                   stop_rgb;

   modport source (
      output valid, kind, sample_0, sample_1, sample_2, sample_3,
             valid_mask, stop_index, stop_rgb,
      input  ready
   );

   modport sink (
      input  valid, kind, sample_0, sample_1, sample_2, sample_3,
             valid_mask, stop_index, stop_rgb,
      output ready
   );
endinterface

[rtl/core/wlpc_rsp_if.sv]
// ----------------------------------------------------------------------------
// wlpc_rsp_if
// result channel: one ARGB word per mapped pixel
// ----------------------------------------------------------------------------
interface wlpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_argb;

   modport source (
      output valid, pixel_argb,
      input  ready
   );

   modport sink (
      input  valid, pixel_argb,
      output ready
   );
endinterface

[rtl/core/window_level_pixel_colormap.sv]
// ----------------------------------------------------------------------------
// window_level_pixel_colormap
// window/level mapping of pixel samples to ARGB with a colour stop ramp
//
//   port     dir   handshake          word
//   req_if   in    valid / ready      pixel samples or stop write
//   rsp_if   out   valid / ready      pixel_argb
//   apb      in    psel / penable     register write, read
//
// one word per cycle while rsp_if is not stalled, 26 register stages
// most of the stages are the 17-step divider, one quotient bit per stage
// reset clears the stage valids and the registers, stop table is not cleared
// a full stage holds while the next one is full and held, so a stall drops nothing
// ----------------------------------------------------------------------------
`include "window_level_pixel_colormap_macros.svh"

module window_level_pixel_colormap #(
   parameter  int MAX_STOPS   = 16,
   parameter  int SAMPLE_BITS = 32,
   localparam int DATA_W      = (SAMPLE_BITS > 32) ? 64 : 32,
   localparam int STRIDE_W    = (SAMPLE_BITS > 32) ? 3 : 2,
   localparam int ADDR_W      = STRIDE_W + wlpc_pkg::REG_IDX_W
) (
   input  logic              clock,
   input  logic              reset,
   wlpc_req_if.sink          req_if,
   wlpc_rsp_if.source        rsp_if,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int SB    = SAMPLE_BITS;
   localparam int DW    = SB + 1;
   localparam int IDX_W = $clog2(MAX_STOPS);
   localparam int CNT_W = IDX_W + 1;
   localparam int S_W   = 16 + IDX_W;
   localparam int NS    = wlpc_pkg::NUM_STAGES;
   localparam int NC    = wlpc_pkg::NUM_CH;
   localparam int TW    = wlpc_pkg::T_W;

   typedef struct packed {
      logic          below;
      logic          above;
      logic [SB-1:0] rem;
      logic [TW-1:0] quo;
   } lane_type;

   // registers
   logic signed [SB-1:0] win_low_ff;
   logic signed [SB-1:0] win_high_ff;
   logic                 invert_ff;
   logic [1:0]           mode_ff;
   logic [15:0]          ramp_begin_ff;
   logic [15:0]          ramp_end_ff;
   logic [31:0]          missing_ff;
   logic [4:0]           stop_count_ff;

   logic                               csr_wr;
   logic [wlpc_pkg::REG_IDX_W-1:0]     csr_idx;

   // derived window values
   logic                 swap;
   logic signed [SB-1:0] lo_sel;
   logic signed [DW-1:0] span_hl;
   logic signed [DW-1:0] span_lh;
   logic [SB-1:0]        span_in;
   logic [SB-1:0]        span_ff;
   logic                 flat_ff;
   logic signed [16:0]   diff_in;
   logic signed [16:0]   diff_ff;
   logic [8:0]           count_wide;
   logic [CNT_W-1:0]     n_stops;
   logic [IDX_W-1:0]     nm1;

   // pipeline control
   logic [NS-1:0]        stage_v_ff;
   logic [NS-1:0]        stage_en;
   wlpc_pkg::side_type   side_ff [wlpc_pkg::ST_RDATA+1];

   // pipeline payload
   logic signed [SB-1:0] samp_ff [NC];
   logic signed [DW-1:0] d_ff [NC];
   lane_type             div_ff [wlpc_pkg::DIV_STEPS+1][NC];
   logic [TW-1:0]        t_ff [NC];
   logic signed [34:0]   prod_ff;
   logic [7:0]           cb_ff [wlpc_pkg::ST_MUL:wlpc_pkg::ST_RDATA][NC];
   logic [15:0]          at_ff;
   logic signed [34:0]   band_rnd;
   logic [S_W-1:0]       s_ff;
   logic [7:0]           gs_ff;
   logic [7:0]           gr_ff;
   logic [15:0]          f_ff;
   logic [IDX_W-1:0]     lo_raw;
   logic [IDX_W-1:0]     lo_idx;
   logic [IDX_W-1:0]     hi_idx;
   logic [23:0]          rd_a_ff;
   logic [23:0]          rd_b_ff;
   logic [23:0]          stop_mem [MAX_STOPS];
   logic                 stop_wr;
   logic [31:0]          pixel_in;
   logic [31:0]          pixel_ff;

   function automatic lane_type make_lane(input logic signed [DW-1:0] d,
                                          input logic [SB-1:0] den);
      lane_type o;
      o.below = d[DW-1] || (d == '0);
      o.above = !o.below && (d[SB-1:0] >= den);
      o.rem   = d[SB-1:0];
      o.quo   = '0;
      return o;
   endfunction

   function automatic lane_type div_step(input lane_type l, input logic [SB-1:0] den);
      logic [SB:0] r2;
      logic        ge;
      lane_type    o;
      r2    = {l.rem, 1'b0};
      ge    = r2 >= {1'b0, den};
      o     = l;
      o.rem = ge ? SB'(r2 - {1'b0, den}) : r2[SB-1:0];
      o.quo = {l.quo[TW-2:0], ge};
      return o;
   endfunction

   function automatic logic [TW-1:0] make_t(input lane_type l, input logic inv,
                                            input logic flat);
      logic [TW:0]   qp;
      logic [TW-1:0] t;
      qp = {1'b0, l.quo} + (TW+1)'(1);
      if (l.below) begin
         t = '0;
      end else if (l.above) begin
         t = wlpc_pkg::ONE_Q16;
      end else begin
         t = qp[TW:1];
      end
      if (inv) begin
         t = wlpc_pkg::ONE_Q16 - t;
      end
      if (flat) begin
         t = wlpc_pkg::HALF_Q16;
      end
      return t;
   endfunction

   // ---------------------------------------------------------------- apb
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[ADDR_W-1:STRIDE_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         win_low_ff    <= '0;
         win_high_ff   <= SB'(255);
         invert_ff     <= 1'b0;
         mode_ff       <= wlpc_pkg::MODE_GRAY;
         ramp_begin_ff <= '0;
         ramp_end_ff   <= 16'hFFFF;
         missing_ff    <= '0;
         stop_count_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            wlpc_pkg::REG_WINDOW_LOW:    win_low_ff    <= pwdata[SB-1:0];
            wlpc_pkg::REG_WINDOW_HIGH:   win_high_ff   <= pwdata[SB-1:0];
            wlpc_pkg::REG_INVERT:        invert_ff     <= pwdata[0];
            wlpc_pkg::REG_COLOR_MODE:    mode_ff       <= pwdata[1:0];
            wlpc_pkg::REG_RAMP_BEGIN:    ramp_begin_ff <= pwdata[15:0];
            wlpc_pkg::REG_RAMP_END:      ramp_end_ff   <= pwdata[15:0];
            wlpc_pkg::REG_MISSING_COLOR: missing_ff    <= pwdata[31:0];
            wlpc_pkg::REG_STOP_COUNT:    stop_count_ff <= pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         wlpc_pkg::REG_WINDOW_LOW:    prdata = DATA_W'(win_low_ff);
         wlpc_pkg::REG_WINDOW_HIGH:   prdata = DATA_W'(win_high_ff);
         wlpc_pkg::REG_INVERT:        prdata = DATA_W'(invert_ff);
         wlpc_pkg::REG_COLOR_MODE:    prdata = DATA_W'(mode_ff);
         wlpc_pkg::REG_RAMP_BEGIN:    prdata = DATA_W'(ramp_begin_ff);
         wlpc_pkg::REG_RAMP_END:      prdata = DATA_W'(ramp_end_ff);
         wlpc_pkg::REG_MISSING_COLOR: prdata = DATA_W'(missing_ff);
         wlpc_pkg::REG_STOP_COUNT:    prdata = DATA_W'(stop_count_ff);
         default:                     prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- window
   assign swap     = win_high_ff < win_low_ff;
   assign lo_sel   = swap ? win_high_ff : win_low_ff;
   assign span_hl  = DW'(win_high_ff) - DW'(win_low_ff);
   assign span_lh  = DW'(win_low_ff) - DW'(win_high_ff);
   assign span_in  = swap ? span_lh[SB-1:0] : span_hl[SB-1:0];
   assign diff_in  = $signed({1'b0, ramp_end_ff}) - $signed({1'b0, ramp_begin_ff});

   assign count_wide = 9'(stop_count_ff);
   assign n_stops    = (count_wide > 9'(MAX_STOPS)) ? CNT_W'(MAX_STOPS) : CNT_W'(count_wide);
   assign nm1        = (n_stops == '0) ? '0 : IDX_W'(n_stops - CNT_W'(1));

   always_ff @(posedge clock) begin
      span_ff <= span_in;
      flat_ff <= (span_in == '0);
      diff_ff <= diff_in;
   end

   // ---------------------------------------------------------------- control
   assign stage_en      = ~stage_v_ff | {rsp_if.ready, stage_en[NS-1:1]};
   assign req_if.ready  = stage_en[wlpc_pkg::ST_IN];
   assign rsp_if.valid  = stage_v_ff[wlpc_pkg::ST_OUT];
   assign rsp_if.pixel_argb = pixel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_v_ff <= '0;
      end else begin
         if (stage_en[wlpc_pkg::ST_IN]) begin
            stage_v_ff[wlpc_pkg::ST_IN] <= req_if.valid;
         end
         for (int k = 1; k < wlpc_pkg::ST_OUT; k++) begin
            if (stage_en[k]) begin
               stage_v_ff[k] <= stage_v_ff[k-1];
            end
         end
         if (stage_en[wlpc_pkg::ST_OUT]) begin
            stage_v_ff[wlpc_pkg::ST_OUT] <= stage_v_ff[wlpc_pkg::ST_RDATA] &&
               (side_ff[wlpc_pkg::ST_RDATA].kind == wlpc_pkg::KIND_PIXEL);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[wlpc_pkg::ST_IN]) begin
         side_ff[wlpc_pkg::ST_IN] <= '{kind: req_if.kind, valid_mask: req_if.valid_mask,
                                       stop_index: req_if.stop_index,
                                       stop_rgb: req_if.stop_rgb};
      end
      for (int k = 1; k <= wlpc_pkg::ST_RDATA; k++) begin
         if (stage_en[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------- front
   always_ff @(posedge clock) begin
      if (stage_en[wlpc_pkg::ST_IN]) begin
         samp_ff[0] <= req_if.sample_0;
         samp_ff[1] <= req_if.sample_1;
         samp_ff[2] <= req_if.sample_2;
         samp_ff[3] <= req_if.sample_3;
      end
      if (stage_en[wlpc_pkg::ST_DIFF]) begin
         for (int c = 0; c < NC; c++) begin
            d_ff[c] <= DW'(samp_ff[c]) - DW'(lo_sel);
         end
      end
      if (stage_en[wlpc_pkg::ST_DIV0]) begin
         for (int c = 0; c < NC; c++) begin
            div_ff[0][c] <= make_lane(d_ff[c], span_ff);
         end
      end
   end

   // ---------------------------------------------------------------- divider
   for (genvar k = 1; k <= wlpc_pkg::DIV_STEPS; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (stage_en[wlpc_pkg::ST_DIV0+k]) begin
            for (int c = 0; c < NC; c++) begin
               div_ff[k][c] <= div_step(div_ff[k-1][c], span_ff);
            end
         end
      end
   end

   // ---------------------------------------------------------------- levels
   assign band_rnd = prod_ff + 35'sd32768;

   always_ff @(posedge clock) begin
      if (stage_en[wlpc_pkg::ST_LEVEL]) begin
         for (int c = 0; c < NC; c++) begin
            t_ff[c] <= make_t(div_ff[wlpc_pkg::DIV_STEPS][c], invert_ff && (c < 3), flat_ff);
         end
      end
      if (stage_en[wlpc_pkg::ST_MUL]) begin
         prod_ff <= $signed({1'b0, t_ff[0]}) * diff_ff;
         for (int c = 0; c < NC; c++) begin
            cb_ff[wlpc_pkg::ST_MUL][c] <= wlpc_pkg::to_byte(t_ff[c]);
         end
      end
      if (stage_en[wlpc_pkg::ST_BAND]) begin
         at_ff <= ramp_begin_ff + band_rnd[31:16];
         cb_ff[wlpc_pkg::ST_BAND] <= cb_ff[wlpc_pkg::ST_MUL];
      end
      if (stage_en[wlpc_pkg::ST_SCALE]) begin
         s_ff  <= S_W'(at_ff) * S_W'(nm1);
         gs_ff <= wlpc_pkg::to_byte({1'b0, at_ff});
         cb_ff[wlpc_pkg::ST_SCALE] <= cb_ff[wlpc_pkg::ST_BAND];
      end
   end

   // ---------------------------------------------------------------- stop table
   assign lo_raw  = s_ff[S_W-1:16];
   assign lo_idx  = (lo_raw > nm1) ? nm1 : lo_raw;
   assign hi_idx  = (lo_idx == nm1) ? nm1 : lo_idx + IDX_W'(1);
   assign stop_wr = stage_v_ff[wlpc_pkg::ST_SCALE] && stage_en[wlpc_pkg::ST_RDATA] &&
                    (side_ff[wlpc_pkg::ST_SCALE].kind == wlpc_pkg::KIND_STOP) &&
                    (9'(side_ff[wlpc_pkg::ST_SCALE].stop_index) < 9'(MAX_STOPS));

   always_ff @(posedge clock) begin
      if (stop_wr) begin
         stop_mem[IDX_W'(side_ff[wlpc_pkg::ST_SCALE].stop_index)] <=
            side_ff[wlpc_pkg::ST_SCALE].stop_rgb;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[wlpc_pkg::ST_RDATA]) begin
         rd_a_ff <= stop_mem[lo_idx];
         rd_b_ff <= stop_mem[hi_idx];
         f_ff    <= s_ff[15:0];
         gr_ff   <= gs_ff;
         cb_ff[wlpc_pkg::ST_RDATA] <= cb_ff[wlpc_pkg::ST_SCALE];
      end
   end

   // ---------------------------------------------------------------- result
   always_comb begin
      logic [3:0] mask;
      logic [3:0] need;
      logic [7:0] alpha;
      mask = side_ff[wlpc_pkg::ST_RDATA].valid_mask;
      need = (mode_ff == wlpc_pkg::MODE_RGB) ? 4'b0111 : 4'b1111;
      alpha = ((mode_ff == wlpc_pkg::MODE_RGB) || flat_ff) ?
              wlpc_pkg::BYTE_MAX : cb_ff[wlpc_pkg::ST_RDATA][3];
      if (mode_ff == wlpc_pkg::MODE_GRAY) begin
         if (!mask[0]) begin
            pixel_in = missing_ff;
         end else if (stop_count_ff == '0) begin
            pixel_in = {wlpc_pkg::BYTE_MAX, gr_ff, gr_ff, gr_ff};
         end else begin
            pixel_in = {wlpc_pkg::BYTE_MAX,
                        wlpc_pkg::blend(rd_a_ff[23:16], rd_b_ff[23:16], f_ff),
                        wlpc_pkg::blend(rd_a_ff[15:8], rd_b_ff[15:8], f_ff),
                        wlpc_pkg::blend(rd_a_ff[7:0], rd_b_ff[7:0], f_ff)};
         end
      end else if ((mask & need) != need) begin
         pixel_in = missing_ff;
      end else begin
         pixel_in = {alpha, cb_ff[wlpc_pkg::ST_RDATA][0], cb_ff[wlpc_pkg::ST_RDATA][1],
                     cb_ff[wlpc_pkg::ST_RDATA][2]};
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[wlpc_pkg::ST_OUT]) begin
         pixel_ff <= pixel_in;
      end
   end

   // ---------------------------------------------------------------- checks
   `WLPC_ASSERT_IMPL(a_out_stall_full, !stage_en[wlpc_pkg::ST_OUT], stage_v_ff[wlpc_pkg::ST_OUT], "output stage stalls while empty")
   `WLPC_ASSERT_NEXT(a_rdata_hold, stage_v_ff[wlpc_pkg::ST_RDATA] && !stage_en[wlpc_pkg::ST_OUT], stage_v_ff[wlpc_pkg::ST_RDATA], "stalled word lost before output")
   `WLPC_ASSERT_IMPL(a_div_rem, stage_v_ff[wlpc_pkg::ST_DIVN] && !div_ff[wlpc_pkg::DIV_STEPS][0].below && !div_ff[wlpc_pkg::DIV_STEPS][0].above && !flat_ff, div_ff[wlpc_pkg::DIV_STEPS][0].rem < span_ff, "divider remainder out of range")
   `WLPC_ASSERT_IMPL(a_level_range, stage_v_ff[wlpc_pkg::ST_LEVEL], t_ff[0] <= wlpc_pkg::ONE_Q16, "ramp position above one")

endmodule
